@@ sv/smemaexc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smemaexc_pkg
// Shared types, step codes and helpers for the exit-conveyor sequencer.
// ----------------------------------------------------------------------------
package smemaexc_pkg;

    // tick timer width and the fixed width of the timeout registers
    localparam int TIMER_BITS  = 20;
    localparam int CFG_TIMER_W = 20;
    localparam int CMP_W       = (TIMER_BITS > CFG_TIMER_W) ? TIMER_BITS : CFG_TIMER_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    typedef logic [TIMER_BITS-1:0]  t_tmr;
    typedef logic [CFG_TIMER_W-1:0] t_lim;

    // step codes
    localparam logic [3:0] ST_STOP       = 4'd0;
    localparam logic [3:0] ST_START      = 4'd1;
    localparam logic [3:0] ST_WAIT_UP    = 4'd2;
    localparam logic [3:0] ST_ACCEPT     = 4'd3;
    localparam logic [3:0] ST_WAIT_POS   = 4'd4;
    localparam logic [3:0] ST_OFFER      = 4'd5;
    localparam logic [3:0] ST_WAIT_DOWN  = 4'd6;
    localparam logic [3:0] ST_WAIT_LEAVE = 4'd7;
    localparam logic [3:0] ST_WAIT_BUSY  = 4'd8;

    // commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // speed profiles
    localparam logic [1:0] SPD_LOW  = 2'd0;
    localparam logic [1:0] SPD_MID  = 2'd1;
    localparam logic [1:0] SPD_HIGH = 2'd2;

    // alarm codes
    localparam logic [1:0] ALM_NONE   = 2'd0;
    localparam logic [1:0] ALM_LOAD   = 2'd1;
    localparam logic [1:0] ALM_UNLOAD = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_TO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNLOAD_TO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_LIMIT = 3'd5;

    localparam t_lim TIMEOUT_RST = t_lim'(1000);

    typedef struct packed {
        logic [1:0] cmd;
        logic       entry_sensor;
        logic       set_sensor;
        logic       upstream_ready;
        logic       downstream_busy;
        logic       terminate_req;
        logic       global_error;
        logic       free_time_enable;
    } t_in;

    typedef struct packed {
        logic [1:0] in_speed;
        logic [1:0] out_speed;
        logic       bypass_mode;
        t_lim       load_timeout;
        t_lim       unload_timeout;
        t_lim       free_time_limit;
    } t_cfg;

    typedef struct packed {
        logic [3:0] step_code;
        logic       belt_on;
        logic [1:0] belt_speed;
        logic       upstream_busy;
        logic       downstream_offer;
        logic [1:0] alarm;
        logic       board_out_pulse;
        logic       wait_lamp_pulse;
        logic       board_arrived_pulse;
        logic       run_ended;
    } t_res;

    // bypass forces mid; code three reads as high
    function automatic logic [1:0] eff_speed(input logic bypass, input logic [1:0] s);
        logic [1:0] r;
        if (bypass) begin
            r = SPD_MID;
        end else if (s > SPD_HIGH) begin
            r = SPD_HIGH;
        end else begin
            r = s;
        end
        return r;
    endfunction

    function automatic t_tmr tmr_inc(input t_tmr t);
        return (&t) ? t : t + t_tmr'(1);
    endfunction

    function automatic logic tmr_gt(input t_tmr t, input t_lim lim);
        logic [CMP_W-1:0] a;
        logic [CMP_W-1:0] b;
        a = CMP_W'(t);
        b = CMP_W'(lim);
        return a > b;
    endfunction

    function automatic logic safe_step(input logic [3:0] s);
        return (s == ST_STOP) || (s == ST_START) || (s == ST_WAIT_UP) ||
               (s == ST_ACCEPT) || (s == ST_OFFER) || (s == ST_WAIT_DOWN);
    endfunction

endpackage

@@ sv/smema_exit_conveyor_control_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smema_exit_conveyor_control_core
// Exit-conveyor SMEMA handshake sequencer, one poll tick per input word.
// ----------------------------------------------------------------------------
// Each input word is one poll tick: command, board sensors, SMEMA lines and
// the termination/error requests. Each tick yields exactly one result word
// with the current step, belt command and speed, the two SMEMA outputs and
// the event pulses and alarm of that tick. The block takes one word per
// clock while the result side does not stall; a word lands in the input
// register, the sequencer evaluates it combinationally, and its result
// moves into the result register as soon as that register is free to
// take a word from the sequencer. A stall on the output holds the result
// register and, one word later, the input register. Configuration registers
// are always ready and are read live by the tick logic; write them only
// while no tick is in flight.
// ----------------------------------------------------------------------------
module smema_exit_conveyor_control_core (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // tick input channel
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic [1:0]                               i_cmd,
    input  logic                                     i_entry_sensor,
    input  logic                                     i_set_sensor,
    input  logic                                     i_upstream_ready,
    input  logic                                     i_downstream_busy,
    input  logic                                     i_terminate_req,
    input  logic                                     i_global_error,
    input  logic                                     i_free_time_enable,
    // result channel
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic [3:0]                               o_step_code,
    output logic                                     o_belt_on,
    output logic [1:0]                               o_belt_speed,
    output logic                                     o_upstream_busy,
    output logic                                     o_downstream_offer,
    output logic [1:0]                               o_alarm,
    output logic                                     o_board_out_pulse,
    output logic                                     o_wait_lamp_pulse,
    output logic                                     o_board_arrived_pulse,
    output logic                                     o_run_ended,
    // configuration write channel
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [smemaexc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [smemaexc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // configuration registers
    smemaexc_pkg::t_cfg r_cfg;

    // input register
    logic               r_in_valid;
    smemaexc_pkg::t_in  r_in;

    // result register
    logic               r_out_valid;
    smemaexc_pkg::t_res r_out;
    smemaexc_pkg::t_res n_out;

    logic               out_free;   // result register can take a word
    logic               adv;        // input word moves into result register
    logic               in_take;    // input register loads a new word

    assign out_free = !r_out_valid || !i_stall;
    assign adv      = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_speed        <= smemaexc_pkg::SPD_MID;
            r_cfg.out_speed       <= smemaexc_pkg::SPD_MID;
            r_cfg.bypass_mode     <= 1'b0;
            r_cfg.load_timeout    <= smemaexc_pkg::TIMEOUT_RST;
            r_cfg.unload_timeout  <= smemaexc_pkg::TIMEOUT_RST;
            r_cfg.free_time_limit <= smemaexc_pkg::TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                smemaexc_pkg::REG_IN_SPEED:   r_cfg.in_speed        <= i_cfg_data[1:0];
                smemaexc_pkg::REG_OUT_SPEED:  r_cfg.out_speed       <= i_cfg_data[1:0];
                smemaexc_pkg::REG_BYPASS:     r_cfg.bypass_mode     <= i_cfg_data[0];
                smemaexc_pkg::REG_LOAD_TO: begin
                    r_cfg.load_timeout <= i_cfg_data[smemaexc_pkg::CFG_TIMER_W-1:0];
                end
                smemaexc_pkg::REG_UNLOAD_TO: begin
                    r_cfg.unload_timeout <= i_cfg_data[smemaexc_pkg::CFG_TIMER_W-1:0];
                end
                smemaexc_pkg::REG_FREE_LIMIT: begin
                    r_cfg.free_time_limit <= i_cfg_data[smemaexc_pkg::CFG_TIMER_W-1:0];
                end
                default: ;  // writes beyond the map are dropped
            endcase
        end
    end

    // input register: loads whenever empty or draining this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.cmd              <= i_cmd;
            r_in.entry_sensor     <= i_entry_sensor;
            r_in.set_sensor       <= i_set_sensor;
            r_in.upstream_ready   <= i_upstream_ready;
            r_in.downstream_busy  <= i_downstream_busy;
            r_in.terminate_req    <= i_terminate_req;
            r_in.global_error     <= i_global_error;
            r_in.free_time_enable <= i_free_time_enable;
        end
    end

    // sequencer state advances exactly once per word passed on
    smemaexc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_word  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (n_out)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_step_code           = r_out.step_code;
    assign o_belt_on             = r_out.belt_on;
    assign o_belt_speed          = r_out.belt_speed;
    assign o_upstream_busy       = r_out.upstream_busy;
    assign o_downstream_offer    = r_out.downstream_offer;
    assign o_alarm               = r_out.alarm;
    assign o_board_out_pulse     = r_out.board_out_pulse;
    assign o_wait_lamp_pulse     = r_out.wait_lamp_pulse;
    assign o_board_arrived_pulse = r_out.board_arrived_pulse;
    assign o_run_ended           = r_out.run_ended;

endmodule

@@ sv/smemaexc_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smemaexc_seq
// Handshake sequencer state and its single-tick next-state logic.
// ----------------------------------------------------------------------------
module smemaexc_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  smemaexc_pkg::t_in   i_word,
    input  smemaexc_pkg::t_cfg  i_cfg,
    output smemaexc_pkg::t_res  o_res
);

    logic [3:0]         r_step,       n_step;
    smemaexc_pkg::t_tmr r_load_tmr,   n_load_tmr;
    smemaexc_pkg::t_tmr r_unload_tmr, n_unload_tmr;
    smemaexc_pkg::t_tmr r_free_tmr,   n_free_tmr;
    logic               r_free_first, n_free_first;
    logic               r_belt,       n_belt;
    logic [1:0]         r_speed,      n_speed;
    logic               r_busy_up,    n_busy_up;
    logic               r_offer,      n_offer;
    logic               r_ended,      n_ended;

    logic               proc;
    logic [1:0]         alarm;
    logic               out_pulse;
    logic               lamp_pulse;
    logic               arr_pulse;
    logic [1:0]         spd_in;
    logic [1:0]         spd_out;
    smemaexc_pkg::t_tmr load_inc;
    smemaexc_pkg::t_tmr unload_inc;
    smemaexc_pkg::t_tmr free_inc;

    assign spd_in     = smemaexc_pkg::eff_speed(i_cfg.bypass_mode, i_cfg.in_speed);
    assign spd_out    = smemaexc_pkg::eff_speed(i_cfg.bypass_mode, i_cfg.out_speed);
    assign load_inc   = smemaexc_pkg::tmr_inc(r_load_tmr);
    assign unload_inc = smemaexc_pkg::tmr_inc(r_unload_tmr);
    assign free_inc   = smemaexc_pkg::tmr_inc(r_free_tmr);

    always_comb begin
        n_step       = r_step;
        n_load_tmr   = r_load_tmr;
        n_unload_tmr = r_unload_tmr;
        n_free_tmr   = r_free_tmr;
        n_free_first = r_free_first;
        n_belt       = r_belt;
        n_speed      = r_speed;
        n_busy_up    = r_busy_up;
        n_offer      = r_offer;
        n_ended      = r_ended;
        proc         = 1'b1;
        alarm        = smemaexc_pkg::ALM_NONE;
        out_pulse    = 1'b0;
        lamp_pulse   = 1'b0;
        arr_pulse    = 1'b0;

        case (i_word.cmd)
            smemaexc_pkg::CMD_RUN: begin
                n_belt       = 1'b0;
                n_speed      = spd_in;
                n_busy_up    = 1'b1;
                n_offer      = 1'b0;
                n_ended      = 1'b0;
                n_load_tmr   = '0;
                n_unload_tmr = '0;
                n_free_tmr   = '0;
                n_free_first = 1'b1;
                n_step       = smemaexc_pkg::ST_STOP;
                proc         = 1'b0;
            end
            smemaexc_pkg::CMD_START: begin
                if (!r_ended) begin
                    n_step = smemaexc_pkg::ST_START;
                end
            end
            smemaexc_pkg::CMD_STOP: begin
                n_step = smemaexc_pkg::ST_STOP;
            end
            default: ;
        endcase

        if (n_ended) begin
            proc = 1'b0;
        end

        // termination only at a safe step
        if (proc && (i_word.terminate_req || i_word.global_error) &&
            smemaexc_pkg::safe_step(n_step)) begin
            n_belt    = 1'b0;
            n_speed   = spd_out;
            n_busy_up = 1'b1;
            n_offer   = 1'b0;
            n_ended   = 1'b1;
            proc      = 1'b0;
        end

        if (proc) begin
            case (n_step)
                smemaexc_pkg::ST_START: begin
                    if (i_word.entry_sensor || i_word.set_sensor) begin
                        n_busy_up    = 1'b1;
                        n_free_first = 1'b1;
                        if (i_word.entry_sensor) begin
                            n_belt  = 1'b1;
                            n_speed = spd_in;
                        end
                        n_load_tmr = '0;
                        n_step     = smemaexc_pkg::ST_WAIT_POS;
                    end else begin
                        n_busy_up = 1'b0;
                        n_offer   = 1'b0;
                        n_step    = smemaexc_pkg::ST_WAIT_UP;
                    end
                end
                smemaexc_pkg::ST_WAIT_UP: begin
                    if (i_word.upstream_ready) begin
                        n_step = smemaexc_pkg::ST_ACCEPT;
                    end
                end
                smemaexc_pkg::ST_ACCEPT: begin
                    n_free_first = 1'b1;
                    n_belt       = 1'b1;
                    n_speed      = spd_in;
                    n_busy_up    = 1'b0;
                    n_load_tmr   = '0;
                    n_step       = smemaexc_pkg::ST_WAIT_POS;
                end
                smemaexc_pkg::ST_WAIT_POS: begin
                    if (i_word.set_sensor) begin
                        n_busy_up = 1'b1;
                        n_belt    = 1'b0;
                        n_speed   = spd_out;
                        arr_pulse = 1'b1;
                        n_step    = smemaexc_pkg::ST_OFFER;
                    end else begin
                        n_load_tmr = load_inc;
                        if (smemaexc_pkg::tmr_gt(load_inc, i_cfg.load_timeout)) begin
                            n_belt  = 1'b0;
                            n_speed = spd_in;
                            alarm   = smemaexc_pkg::ALM_LOAD;
                            n_step  = smemaexc_pkg::ST_STOP;
                        end
                    end
                end
                smemaexc_pkg::ST_OFFER: begin
                    n_offer = 1'b1;
                    n_step  = smemaexc_pkg::ST_WAIT_DOWN;
                end
                smemaexc_pkg::ST_WAIT_DOWN: begin
                    if (!i_word.downstream_busy) begin
                        n_free_first = 1'b1;
                        n_belt       = 1'b1;
                        n_speed      = spd_out;
                        out_pulse    = 1'b1;
                        n_unload_tmr = '0;
                        n_step       = smemaexc_pkg::ST_WAIT_LEAVE;
                    end else if (!i_word.set_sensor) begin
                        n_step = smemaexc_pkg::ST_START;
                    end else if (i_word.free_time_enable) begin
                        if (r_free_first) begin
                            n_free_tmr   = '0;
                            n_free_first = 1'b0;
                        end else if (smemaexc_pkg::tmr_gt(free_inc,
                                                          i_cfg.free_time_limit)) begin
                            lamp_pulse = 1'b1;
                            n_free_tmr = '0;
                        end else begin
                            n_free_tmr = free_inc;
                        end
                    end
                end
                smemaexc_pkg::ST_WAIT_LEAVE, smemaexc_pkg::ST_WAIT_BUSY: begin
                    if ((n_step == smemaexc_pkg::ST_WAIT_LEAVE) && !i_word.set_sensor) begin
                        n_free_first = 1'b1;
                        n_step       = smemaexc_pkg::ST_WAIT_BUSY;
                    end else if ((n_step == smemaexc_pkg::ST_WAIT_BUSY) &&
                                 i_word.downstream_busy) begin
                        n_belt  = 1'b0;
                        n_speed = spd_out;
                        n_step  = smemaexc_pkg::ST_START;
                    end else begin
                        n_unload_tmr = unload_inc;
                        if (smemaexc_pkg::tmr_gt(unload_inc, i_cfg.unload_timeout)) begin
                            n_belt  = 1'b0;
                            n_speed = spd_in;
                            alarm   = smemaexc_pkg::ALM_UNLOAD;
                            n_step  = smemaexc_pkg::ST_STOP;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= smemaexc_pkg::ST_STOP;
            r_load_tmr   <= '0;
            r_unload_tmr <= '0;
            r_free_tmr   <= '0;
            r_free_first <= 1'b1;
            r_belt       <= 1'b0;
            r_speed      <= smemaexc_pkg::SPD_MID;
            r_busy_up    <= 1'b1;
            r_offer      <= 1'b0;
            r_ended      <= 1'b0;
        end else if (i_adv) begin
            r_step       <= n_step;
            r_load_tmr   <= n_load_tmr;
            r_unload_tmr <= n_unload_tmr;
            r_free_tmr   <= n_free_tmr;
            r_free_first <= n_free_first;
            r_belt       <= n_belt;
            r_speed      <= n_speed;
            r_busy_up    <= n_busy_up;
            r_offer      <= n_offer;
            r_ended      <= n_ended;
        end
    end

    always_comb begin
        o_res.step_code           = n_step;
        o_res.belt_on             = n_belt;
        o_res.belt_speed          = n_speed;
        o_res.upstream_busy       = n_busy_up;
        o_res.downstream_offer    = n_offer;
        o_res.alarm               = alarm;
        o_res.board_out_pulse     = out_pulse;
        o_res.wait_lamp_pulse     = lamp_pulse;
        o_res.board_arrived_pulse = arr_pulse;
        o_res.run_ended           = n_ended;
    end

endmodule

@@ sv/smemaexc_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smemaexc_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module smemaexc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_step_code,
    input logic       o_belt_on,
    input logic       o_upstream_busy,
    input logic       o_downstream_offer,
    input logic [1:0] o_alarm,
    input logic       o_board_out_pulse,
    input logic       o_board_arrived_pulse,
    input logic       o_run_ended
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_step_code) && $stable(o_alarm))
        else $error("result word changed under stall");

    // a timeout stops the line with the belt off
    a_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_alarm != smemaexc_pkg::ALM_NONE) |->
            (o_step_code == smemaexc_pkg::ST_STOP) && !o_belt_on)
        else $error("alarm without stop");

    // arrival parks the board and blocks upstream
    a_arrive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_board_arrived_pulse |->
            (o_step_code == smemaexc_pkg::ST_OFFER) && !o_belt_on && o_upstream_busy)
        else $error("bad arrival outputs");

    // unloading starts with belt running
    a_unload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_board_out_pulse |->
            (o_step_code == smemaexc_pkg::ST_WAIT_LEAVE) && o_belt_on)
        else $error("bad unload outputs");

    // an ended run keeps its outputs in the safe state
    a_ended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_run_ended |-> !o_belt_on && !o_downstream_offer && o_upstream_busy)
        else $error("ended run with live outputs");

endmodule

bind smema_exit_conveyor_control_core smemaexc_chk u_chk (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_valid               (o_valid),
    .i_stall               (i_stall),
    .o_step_code           (o_step_code),
    .o_belt_on             (o_belt_on),
    .o_upstream_busy       (o_upstream_busy),
    .o_downstream_offer    (o_downstream_offer),
    .o_alarm               (o_alarm),
    .o_board_out_pulse     (o_board_out_pulse),
    .o_board_arrived_pulse (o_board_arrived_pulse),
    .o_run_ended           (o_run_ended)
);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the exit-conveyor SMEMA sequencer core.
// ----------------------------------------------------------------------------
// Poll-tick words are fed from a queue by a bursty driver. A monitor keeps
// its own copy of the sequencer and predicts one status word per accepted
// tick, then checks every returned word field by field. The result side
// stalls on changing patterns. The run opens with hand-written board cycles,
// timeouts and end-of-run cases, then walks through several register
// settings with randomised board passes, noise and odd commands.
// ----------------------------------------------------------------------------
module tb;

    import smemaexc_pkg::*;

    // receiver stall patterns
    typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC, RX_LONG} rx_pattern_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // tick channel
    logic drv_valid = 1'b0;
    t_in  drv_word  = '0;
    logic dut_stall;

    // result channel
    logic res_valid;
    logic rx_stall = 1'b0;
    t_res dut_status;

    // register write channel
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // stimulus and expectations
    t_in  tick_queue[$];
    t_res status_due[$];
    bit   word_taken   = 1'b0;
    bit   maybe_ended  = 1'b0;
    int   words_queued = 0;

    // driver burst shaping
    int burst_left = 1;
    int gap_left   = 0;

    // receiver pattern state
    rx_pattern_e stall_mode = RX_FREE;
    int          stall_left = 0;
    int          stall_cyc  = 0;

    // bookkeeping
    int err_count = 0;
    int n_checked = 0;
    int n_alarms  = 0;
    int n_lamps   = 0;
    int n_boards  = 0;
    int n_arrived = 0;

    // predicted sequencer state and register copy
    t_cfg       cfg;
    logic [3:0] seq_step;
    t_tmr       load_tmr, unload_tmr, free_tmr;
    logic       free_first, belt_running, busy_up, offer_dn, ended;
    logic [1:0] belt_spd;

    always #5 clk = ~clk;

    smema_exit_conveyor_control_core DUT (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_valid               (drv_valid),
        .o_stall               (dut_stall),
        .i_cmd                 (drv_word.cmd),
        .i_entry_sensor        (drv_word.entry_sensor),
        .i_set_sensor          (drv_word.set_sensor),
        .i_upstream_ready      (drv_word.upstream_ready),
        .i_downstream_busy     (drv_word.downstream_busy),
        .i_terminate_req       (drv_word.terminate_req),
        .i_global_error        (drv_word.global_error),
        .i_free_time_enable    (drv_word.free_time_enable),
        .o_valid               (res_valid),
        .i_stall               (rx_stall),
        .o_step_code           (dut_status.step_code),
        .o_belt_on             (dut_status.belt_on),
        .o_belt_speed          (dut_status.belt_speed),
        .o_upstream_busy       (dut_status.upstream_busy),
        .o_downstream_offer    (dut_status.downstream_offer),
        .o_alarm               (dut_status.alarm),
        .o_board_out_pulse     (dut_status.board_out_pulse),
        .o_wait_lamp_pulse     (dut_status.wait_lamp_pulse),
        .o_board_arrived_pulse (dut_status.board_arrived_pulse),
        .o_run_ended           (dut_status.run_ended),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (cfg_ready),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data)
    );

    // ------------------------------------------------------------------
    // Sequencer prediction
    // ------------------------------------------------------------------

    task automatic clear_prediction();
        cfg.in_speed        = SPD_MID;
        cfg.out_speed       = SPD_MID;
        cfg.bypass_mode     = 1'b0;
        cfg.load_timeout    = TIMEOUT_RST;
        cfg.unload_timeout  = TIMEOUT_RST;
        cfg.free_time_limit = TIMEOUT_RST;
        seq_step     = ST_STOP;
        load_tmr     = '0;
        unload_tmr   = '0;
        free_tmr     = '0;
        free_first   = 1'b1;
        belt_running = 1'b0;
        belt_spd     = SPD_MID;
        busy_up      = 1'b1;
        offer_dn     = 1'b0;
        ended        = 1'b0;
    endtask

    // belt command; bypass pins mid, the unused code reads as high
    task automatic set_belt(input logic on, input logic [1:0] spd);
        belt_running = on;
        if (cfg.bypass_mode)
            belt_spd = SPD_MID;
        else if (spd > SPD_HIGH)
            belt_spd = SPD_HIGH;
        else
            belt_spd = spd;
    endtask

    // saturating tick count
    function automatic t_tmr bump(input t_tmr t);
        return (&t) ? t : t + t_tmr'(1);
    endfunction

    task automatic conveyor_tick(input t_in w, output t_res r);
        logic       go;
        logic [1:0] alm;
        logic       out_p, lamp_p, arr_p;
        go     = 1'b1;
        alm    = ALM_NONE;
        out_p  = 1'b0;
        lamp_p = 1'b0;
        arr_p  = 1'b0;

        case (w.cmd)
            CMD_RUN: begin
                set_belt(1'b0, cfg.in_speed);
                busy_up    = 1'b1;
                offer_dn   = 1'b0;
                ended      = 1'b0;
                load_tmr   = '0;
                unload_tmr = '0;
                free_tmr   = '0;
                free_first = 1'b1;
                seq_step   = ST_STOP;
                go         = 1'b0;
            end
            CMD_START: begin
                if (!ended) seq_step = ST_START;
            end
            CMD_STOP: seq_step = ST_STOP;
            default: ;
        endcase

        if (ended) go = 1'b0;

        // end of run only at a safe step
        if (go && (w.terminate_req || w.global_error) &&
            (seq_step inside {ST_STOP, ST_START, ST_WAIT_UP, ST_ACCEPT,
                              ST_OFFER, ST_WAIT_DOWN})) begin
            set_belt(1'b0, cfg.out_speed);
            busy_up  = 1'b1;
            offer_dn = 1'b0;
            ended    = 1'b1;
            go       = 1'b0;
        end

        if (go) begin
            case (seq_step)
                ST_START: begin
                    if (w.entry_sensor || w.set_sensor) begin
                        busy_up    = 1'b1;
                        free_first = 1'b1;
                        if (w.entry_sensor) set_belt(1'b1, cfg.in_speed);
                        load_tmr   = '0;
                        seq_step   = ST_WAIT_POS;
                    end else begin
                        busy_up  = 1'b0;
                        offer_dn = 1'b0;
                        seq_step = ST_WAIT_UP;
                    end
                end
                ST_WAIT_UP: begin
                    if (w.upstream_ready) seq_step = ST_ACCEPT;
                end
                ST_ACCEPT: begin
                    free_first = 1'b1;
                    set_belt(1'b1, cfg.in_speed);
                    busy_up    = 1'b0;
                    load_tmr   = '0;
                    seq_step   = ST_WAIT_POS;
                end
                ST_WAIT_POS: begin
                    if (w.set_sensor) begin
                        busy_up = 1'b1;
                        set_belt(1'b0, cfg.out_speed);
                        arr_p    = 1'b1;
                        seq_step = ST_OFFER;
                    end else begin
                        load_tmr = bump(load_tmr);
                        if (load_tmr > cfg.load_timeout) begin
                            set_belt(1'b0, cfg.in_speed);
                            alm      = ALM_LOAD;
                            seq_step = ST_STOP;
                        end
                    end
                end
                ST_OFFER: begin
                    offer_dn = 1'b1;
                    seq_step = ST_WAIT_DOWN;
                end
                ST_WAIT_DOWN: begin
                    if (!w.downstream_busy) begin
                        free_first = 1'b1;
                        set_belt(1'b1, cfg.out_speed);
                        out_p      = 1'b1;
                        unload_tmr = '0;
                        seq_step   = ST_WAIT_LEAVE;
                    end else if (!w.set_sensor) begin
                        seq_step = ST_START;
                    end else if (w.free_time_enable) begin
                        if (free_first) begin
                            free_tmr   = '0;
                            free_first = 1'b0;
                        end else begin
                            free_tmr = bump(free_tmr);
                            if (free_tmr > cfg.free_time_limit) begin
                                lamp_p   = 1'b1;
                                free_tmr = '0;
                            end
                        end
                    end
                end
                ST_WAIT_LEAVE, ST_WAIT_BUSY: begin
                    if (seq_step == ST_WAIT_LEAVE && !w.set_sensor) begin
                        free_first = 1'b1;
                        seq_step   = ST_WAIT_BUSY;
                    end else if (seq_step == ST_WAIT_BUSY && w.downstream_busy) begin
                        set_belt(1'b0, cfg.out_speed);
                        seq_step = ST_START;
                    end else begin
                        unload_tmr = bump(unload_tmr);
                        if (unload_tmr > cfg.unload_timeout) begin
                            set_belt(1'b0, cfg.in_speed);
                            alm      = ALM_UNLOAD;
                            seq_step = ST_STOP;
                        end
                    end
                end
                default: ;
            endcase
        end

        r.step_code           = seq_step;
        r.belt_on             = belt_running;
        r.belt_speed          = belt_spd;
        r.upstream_busy       = busy_up;
        r.downstream_offer    = offer_dn;
        r.alarm               = alm;
        r.board_out_pulse     = out_p;
        r.wait_lamp_pulse     = lamp_p;
        r.board_arrived_pulse = arr_p;
        r.run_ended           = ended;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        err_count++;
        $display("%0t ns  status word %0d: %s got %0d want %0d",
                 $time, n_checked, what, got, want);
    endtask

    task automatic check_status(input t_res got, input t_res want);
        if (got.step_code !== want.step_code)
            flag_mismatch("step_code", 32'(got.step_code), 32'(want.step_code));
        if (got.belt_on !== want.belt_on)
            flag_mismatch("belt_on", 32'(got.belt_on), 32'(want.belt_on));
        if (got.belt_speed !== want.belt_speed)
            flag_mismatch("belt_speed", 32'(got.belt_speed), 32'(want.belt_speed));
        if (got.upstream_busy !== want.upstream_busy)
            flag_mismatch("upstream_busy", 32'(got.upstream_busy),
                          32'(want.upstream_busy));
        if (got.downstream_offer !== want.downstream_offer)
            flag_mismatch("downstream_offer", 32'(got.downstream_offer),
                          32'(want.downstream_offer));
        if (got.alarm !== want.alarm)
            flag_mismatch("alarm", 32'(got.alarm), 32'(want.alarm));
        if (got.board_out_pulse !== want.board_out_pulse)
            flag_mismatch("board_out_pulse", 32'(got.board_out_pulse),
                          32'(want.board_out_pulse));
        if (got.wait_lamp_pulse !== want.wait_lamp_pulse)
            flag_mismatch("wait_lamp_pulse", 32'(got.wait_lamp_pulse),
                          32'(want.wait_lamp_pulse));
        if (got.board_arrived_pulse !== want.board_arrived_pulse)
            flag_mismatch("board_arrived_pulse", 32'(got.board_arrived_pulse),
                          32'(want.board_arrived_pulse));
        if (got.run_ended !== want.run_ended)
            flag_mismatch("run_ended", 32'(got.run_ended), 32'(want.run_ended));
    endtask

    // Monitor: predict on each accepted tick first, then check the result
    // side, so an expectation is always queued before its word can return.
    always @(posedge clk) begin : monitor
        t_res want;
        if (rst_n) begin
            if (drv_valid && !dut_stall) begin
                conveyor_tick(drv_word, want);
                status_due.push_back(want);
                word_taken = 1'b1;
            end
            if (res_valid && !rx_stall) begin
                if (status_due.size() == 0) begin
                    flag_mismatch("unexpected result word", 32'(dut_status), '0);
                end else begin
                    want = status_due.pop_front();
                    check_status(dut_status, want);
                    n_checked++;
                    if (want.alarm != ALM_NONE) n_alarms++;
                    n_lamps   += int'(want.wait_lamp_pulse);
                    n_boards  += int'(want.board_out_pulse);
                    n_arrived += int'(want.board_arrived_pulse);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of random length, gaps between them, payload held
    // while stalled.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : driver
        int r;
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else if (!(drv_valid && !word_taken)) begin
            word_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                drv_valid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
                drv_word  <= tick_queue.pop_front();
                drv_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    r = $urandom_range(0, 7);
                    burst_left = (r == 7) ? $urandom_range(60, 200) : $urandom_range(1, 40);
                    if (r == 0)
                        gap_left = $urandom_range(6, 25);
                    else if (r < 3)
                        gap_left = 0;
                    else
                        gap_left = $urandom_range(1, 3);
                end
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure: a new pattern is drawn whenever the current one runs out
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = rx_pattern_e'($urandom_range(0, 4));
            stall_left = $urandom_range(30, 200);
        end else begin
            stall_left--;
        end
        stall_cyc++;
        case (stall_mode)
            RX_FREE:     rx_stall <= 1'b0;
            RX_LIGHT:    rx_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY:    rx_stall <= ($urandom_range(0, 9) < 7);
            RX_PERIODIC: rx_stall <= ((stall_cyc % 7) < 3);
            default:     rx_stall <= ((stall_cyc % 23) < 12);
        endcase
    end

    // ------------------------------------------------------------------
    // Register writes (caller sits just after a falling edge)
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_IN_SPEED:   cfg.in_speed        = d[1:0];
            REG_OUT_SPEED:  cfg.out_speed       = d[1:0];
            REG_BYPASS:     cfg.bypass_mode     = d[0];
            REG_LOAD_TO:    cfg.load_timeout    = d[CFG_TIMER_W-1:0];
            REG_UNLOAD_TO:  cfg.unload_timeout  = d[CFG_TIMER_W-1:0];
            REG_FREE_LIMIT: cfg.free_time_limit = d[CFG_TIMER_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic program_config(input t_cfg c);
        @(negedge clk);
        write_reg(REG_IN_SPEED,   CFG_DATA_W'(c.in_speed));
        write_reg(REG_OUT_SPEED,  CFG_DATA_W'(c.out_speed));
        write_reg(REG_BYPASS,     CFG_DATA_W'(c.bypass_mode));
        write_reg(REG_LOAD_TO,    CFG_DATA_W'(c.load_timeout));
        write_reg(REG_UNLOAD_TO,  CFG_DATA_W'(c.unload_timeout));
        write_reg(REG_FREE_LIMIT, CFG_DATA_W'(c.free_time_limit));
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_in tick_word(input logic [1:0] c, input int ent, input int setp,
                                      input int up, input int dn, input int term,
                                      input int gerr, input int ft);
        t_in w;
        w.cmd              = c;
        w.entry_sensor     = ent[0];
        w.set_sensor       = setp[0];
        w.upstream_ready   = up[0];
        w.downstream_busy  = dn[0];
        w.terminate_req    = term[0];
        w.global_error     = gerr[0];
        w.free_time_enable = ft[0];
        return w;
    endfunction

    function automatic t_in any_tick();
        logic [31:0] raw;
        raw = $urandom;
        return t_in'(raw[$bits(t_in)-1:0]);
    endfunction

    // plain poll tick with random don't-care lines and rare disturbances
    function automatic t_in loose_tick();
        t_in w;
        w = any_tick();
        w.cmd           = CMD_TICK;
        w.terminate_req = ($urandom_range(0, 119) == 0);
        w.global_error  = ($urandom_range(0, 159) == 0);
        if ($urandom_range(0, 79) == 0) w.cmd = 2'($urandom_range(0, 3));
        return w;
    endfunction

    task automatic push_tick(input t_in w);
        if (w.terminate_req || w.global_error || w.cmd != CMD_TICK) maybe_ended = 1'b1;
        tick_queue.push_back(w);
        words_queued++;
    endtask

    // One board through the exit conveyor with random dwell at each wait.
    task automatic queue_board_pass();
        t_in w;
        int  v;
        if (maybe_ended || $urandom_range(0, 4) == 0) begin
            w = loose_tick();
            w.cmd = CMD_RUN;
            maybe_ended = 1'b0;
            push_tick(w);
        end

        w = loose_tick();
        w.cmd = ($urandom_range(0, 5) == 0) ? CMD_TICK : CMD_START;
        v = $urandom_range(0, 5);
        w.entry_sensor = (v == 0);
        w.set_sensor   = (v == 1);
        push_tick(w);

        if (v > 1) begin
            // wait upstream, then accept
            repeat ($urandom_range(0, 3)) begin
                w = loose_tick();
                w.upstream_ready = 1'b0;
                push_tick(w);
            end
            w = loose_tick();
            w.upstream_ready = 1'b1;
            push_tick(w);
            push_tick(loose_tick());
        end

        // travel to the set position
        repeat ($urandom_range(0, 6)) begin
            w = loose_tick();
            w.set_sensor = 1'b0;
            push_tick(w);
        end
        w = loose_tick();
        w.set_sensor = 1'b1;
        push_tick(w);

        // offer, then downstream busy for a while
        push_tick(loose_tick());
        repeat ($urandom_range(0, 10)) begin
            w = loose_tick();
            w.downstream_busy  = 1'b1;
            w.set_sensor       = 1'b1;
            w.free_time_enable = ($urandom_range(0, 4) != 0);
            push_tick(w);
        end
        if ($urandom_range(0, 7) == 0) begin
            // board removed while waiting: back to start
            w = loose_tick();
            w.downstream_busy = 1'b1;
            w.set_sensor      = 1'b0;
            push_tick(w);
            return;
        end
        w = loose_tick();
        w.downstream_busy = 1'b0;
        push_tick(w);

        // board leaving, then downstream takes it
        repeat ($urandom_range(0, 5)) begin
            w = loose_tick();
            w.set_sensor = 1'b1;
            push_tick(w);
        end
        w = loose_tick();
        w.set_sensor = 1'b0;
        push_tick(w);
        repeat ($urandom_range(0, 5)) begin
            w = loose_tick();
            w.downstream_busy = 1'b0;
            push_tick(w);
        end
        w = loose_tick();
        w.downstream_busy = 1'b1;
        push_tick(w);
    endtask

    task automatic fill_random(input int count);
        int stop_at;
        stop_at = words_queued + count;
        while (words_queued < stop_at) begin
            if ($urandom_range(0, 6) != 0) begin
                queue_board_pass();
            end else begin
                repeat ($urandom_range(1, 6)) push_tick(any_tick());
            end
        end
    endtask

    function automatic t_lim pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return t_lim'(1);
            2:       return t_lim'($urandom_range(2, 12));
            3:       return t_lim'($urandom_range(2, 40));
            4:       return '1;
            default: return t_lim'($urandom);
        endcase
    endfunction

    // wait until every queued tick is in and every status word is back
    task automatic wait_idle(input int settle);
        do @(posedge clk);
        while (tick_queue.size() != 0 || drv_valid || status_due.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        t_cfg c;
        clear_prediction();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset registers: a full board cycle, a request at an unsafe step,
        // error at the offer, then start/stop while ended and a restart.
        push_tick(tick_word(CMD_START, 0, 0, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  0, 0, 1, 0, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  1, 0, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  0, 1, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  0, 1, 0, 1, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  0, 1, 0, 1, 0, 0, 1));
        push_tick(tick_word(CMD_TICK,  0, 1, 0, 0, 0, 0, 1));
        push_tick(tick_word(CMD_TICK,  0, 0, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  0, 0, 0, 1, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  1, 0, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  1, 0, 0, 0, 1, 0, 0));
        push_tick(tick_word(CMD_TICK,  0, 1, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  0, 1, 0, 1, 0, 1, 0));
        push_tick(tick_word(CMD_START, 1, 1, 1, 1, 1, 1, 1));
        push_tick(tick_word(CMD_STOP,  0, 0, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_RUN,   1, 1, 1, 1, 1, 1, 1));
        wait_idle(4);

        // Zero limits: load timeout, lamp on the second counted tick,
        // unload timeout; speed code three reads as high.
        c.in_speed        = 2'($urandom_range(3, 3));
        c.out_speed       = SPD_LOW;
        c.bypass_mode     = 1'b0;
        c.load_timeout    = '0;
        c.unload_timeout  = '0;
        c.free_time_limit = '0;
        program_config(c);
        push_tick(tick_word(CMD_RUN,   0, 0, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_START, 1, 0, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  0, 0, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_START, 0, 1, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  0, 1, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  0, 1, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  0, 1, 0, 1, 0, 0, 1));
        push_tick(tick_word(CMD_TICK,  0, 1, 0, 1, 0, 0, 1));
        push_tick(tick_word(CMD_TICK,  0, 1, 0, 0, 0, 0, 0));
        push_tick(tick_word(CMD_TICK,  0, 1, 0, 0, 0, 0, 0));
        wait_idle(4);

        // Random phases, each under its own register set. Half of each
        // phase drains fully before the rest goes in.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    c.in_speed        = 2'($urandom_range(3, 3));
                    c.out_speed       = SPD_HIGH;
                    c.bypass_mode     = 1'b0;
                    c.load_timeout    = '1;
                    c.unload_timeout  = '1;
                    c.free_time_limit = '1;
                end
                1: begin
                    c.in_speed        = SPD_LOW;
                    c.out_speed       = SPD_HIGH;
                    c.bypass_mode     = 1'b1;
                    c.load_timeout    = t_lim'(3);
                    c.unload_timeout  = t_lim'(5);
                    c.free_time_limit = t_lim'(2);
                end
                default: begin
                    c.in_speed        = 2'($urandom_range(0, 3));
                    c.out_speed       = 2'($urandom_range(0, 3));
                    c.bypass_mode     = ($urandom_range(0, 3) == 0);
                    c.load_timeout    = pick_limit();
                    c.unload_timeout  = pick_limit();
                    c.free_time_limit = pick_limit();
                end
            endcase
            program_config(c);
            fill_random(115);
            wait_idle(0);
            fill_random(115);
            wait_idle(4);
        end

        $display("Checked %0d status words over 10 register settings.", n_checked);
        $display("Boards arrived %0d, unloaded %0d; alarms %0d, wait-lamp pulses %0d.",
                 n_arrived, n_boards, n_alarms, n_lamps);
        if (err_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // watchdog: well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Timed out with %0d status words outstanding.", status_due.size());
        $display("tb NOT OK");
        $finish;
    end

endmodule
